>>> rtl/core/scl_pkg.sv
// Shared types, token kinds and character classes of the source code lexer.
package scl_pkg;

  localparam int OFFSET_WIDTH_DEFAULT = 16;

  localparam logic [6:0] K_END   = 7'd0;
  localparam logic [6:0] K_NL    = 7'd1;
  localparam logic [6:0] K_SEMI  = 7'd2;
  localparam logic [6:0] K_DEC   = 7'd3;
  localparam logic [6:0] K_OCT   = 7'd4;
  localparam logic [6:0] K_HEX   = 7'd5;
  localparam logic [6:0] K_BIN   = 7'd6;
  localparam logic [6:0] K_IDENT = 7'd7;
  localparam logic [6:0] K_KW0   = 7'd8;
  localparam logic [6:0] K_ERR   = 7'd29;
  localparam logic [6:0] K_INC   = 7'd63;
  localparam logic [6:0] K_DECR  = 7'd64;
  localparam logic [6:0] K_LAND  = 7'd65;
  localparam logic [6:0] K_LOR   = 7'd66;
  localparam logic [6:0] K_PLUS  = 7'd44;
  localparam logic [6:0] K_MINUS = 7'd46;
  localparam logic [6:0] K_AMP   = 7'd55;
  localparam logic [6:0] K_PIPE  = 7'd57;

  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  typedef enum logic [3:0] {
    M_IDLE, M_DEC, M_ZERO, M_OCT, M_HEXP, M_HEX, M_BINP, M_BIN, M_IDENT, M_OPER
  } mode_t;

  typedef struct packed {
    logic       valid;
    logic [6:0] kind;
    logic       at_begin;
    logic [1:0] len_sel;
  } tok_t;

  localparam logic [1:0] LEN_ONE  = 2'd0;
  localparam logic [1:0] LEN_TWO  = 2'd1;
  localparam logic [1:0] LEN_SIZE = 2'd2;
  localparam logic [1:0] LEN_ZERO = 2'd3;

  function automatic logic is_dig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_oct(input logic [7:0] c);
    return c >= "0" && c <= "7";
  endfunction

  function automatic logic is_hexc(input logic [7:0] c);
    return is_dig(c) || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic [6:0] one_kind(input logic [7:0] c);
    case (c)
      "(": return 7'd30;
      ")": return 7'd31;
      "[": return 7'd32;
      "]": return 7'd33;
      "{": return 7'd34;
      "}": return 7'd35;
      ":": return 7'd40;
      "?": return 7'd41;
      "~": return 7'd54;
      default: return 7'd0;
    endcase
  endfunction

  function automatic logic [6:0] dbl_kind(input logic [7:0] c);
    case (c)
      "<": return 7'd36;
      ">": return 7'd38;
      "!": return 7'd42;
      "+": return 7'd44;
      "-": return 7'd46;
      "*": return 7'd48;
      "/": return 7'd50;
      "%": return 7'd52;
      "&": return 7'd55;
      "|": return 7'd57;
      "^": return 7'd59;
      "=": return 7'd61;
      default: return 7'd0;
    endcase
  endfunction

  function automatic logic [6:0] kw_kind(input logic [39:0] b);
    case (b)
      40'h0000726176: return 7'd8;
      40'h74736E6F63: return 7'd9;
      40'h0000003875: return 7'd10;
      40'h0000363175: return 7'd11;
      40'h0000323375: return 7'd12;
      40'h0000343675: return 7'd13;
      40'h0038323175: return 7'd14;
      40'h657A697375: return 7'd15;
      40'h0000003869: return 7'd16;
      40'h0000363169: return 7'd17;
      40'h0000323369: return 7'd18;
      40'h0000343669: return 7'd19;
      40'h0038323169: return 7'd20;
      40'h657A697369: return 7'd21;
      40'h0000323366: return 7'd22;
      40'h0000343666: return 7'd23;
      40'h657A697366: return 7'd24;
      40'h00657A6973: return 7'd25;
      40'h0072616863: return 7'd26;
      40'h0000727473: return 7'd27;
      40'h006C6F6F62: return 7'd28;
      default: return K_IDENT;
    endcase
  endfunction

endpackage

>>> rtl/core/source_code_lexer.sv
// Top level of the source code lexer: input register, decode, two-entry result queue.
// A token caused by a byte passes through the input register and then the result queue before it is offered.
// One byte per cycle while the input is not stalled; a byte that yields two tokens offers them in turn.
// Input stalls while a queued token is stalled, or while two are queued and the byte needs two.
// Reset clears scan state, offsets and the result queue; payload registers are not reset.
module source_code_lexer #(
  parameter int OFFSET_WIDTH = scl_pkg::OFFSET_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  character,
  input  logic        end_mark,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  token_kind,
  output logic [15:0] token_start,
  output logic [15:0] token_length,
  output logic        last_of_run
);

  typedef struct packed {
    logic [6:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic        last;
  } res_t;

  logic                    r_valid;
  logic [7:0]              r_char;
  logic                    r_end;
  scl_pkg::mode_t          mode;
  logic [OFFSET_WIDTH-1:0] offset;
  logic [OFFSET_WIDTH-1:0] tbegin;
  logic [15:0]             tsize;
  logic [6:0]              op_kind;
  logic [39:0]             kw_buf;
  logic                    kw_ok;
  res_t                    q [2];
  logic [1:0]              q_cnt;

  scl_pkg::mode_t mode_next;
  logic [39:0]    kw_buf_next;
  logic           kw_ok_next;
  logic [6:0]     op_kind_next;
  logic           extend;
  logic           restart;
  scl_pkg::tok_t  tok_a;
  scl_pkg::tok_t  tok_b;
  logic           step;
  logic           pop;
  logic [1:0]     n_new;
  res_t           ra;
  res_t           rb;
  logic [2:0]     kw_count;

  assign kw_count = (tsize > 16'd5) ? 3'd5 : tsize[2:0];

  scl_step u_step (
    .mode(mode), .kw_count(kw_count), .kw_buf(kw_buf), .kw_ok(kw_ok), .op_kind(op_kind),
    .character(r_char), .end_mark(r_end), .mode_next(mode_next),
    .kw_buf_next(kw_buf_next), .kw_ok_next(kw_ok_next), .op_kind_next(op_kind_next),
    .extend(extend), .restart(restart), .tok_a(tok_a), .tok_b(tok_b)
  );

  function automatic res_t make_res(input scl_pkg::tok_t t, input logic [15:0] b,
                                    input logic [15:0] c, input logic [15:0] sz,
                                    input logic last);
    res_t r;
    r.kind = t.kind;
    r.start = t.at_begin ? b : c;
    case (t.len_sel)
      scl_pkg::LEN_ONE: r.len = 16'd1;
      scl_pkg::LEN_TWO: r.len = 16'd2;
      scl_pkg::LEN_SIZE: r.len = sz;
      default: r.len = 16'd0;
    endcase
    r.last = last;
    return r;
  endfunction

  logic [15:0] b16;
  logic [15:0] c16;
  if (OFFSET_WIDTH >= 16) begin : g_wide
    assign b16 = tbegin[15:0];
    assign c16 = offset[15:0];
  end else begin : g_narrow
    assign b16 = 16'(tbegin);
    assign c16 = 16'(offset);
  end

  assign ra = make_res(tok_a, b16, c16, tsize, !tok_b.valid);
  assign rb = make_res(tok_b, b16, c16, tsize, 1'b1);
  assign n_new = {1'b0, tok_a.valid} + {1'b0, tok_b.valid};

  assign pop = out_valid && !out_stall;
  // A decoded byte may produce two tokens, so it proceeds only if the queue, after any pop, has room for all it yields.
  assign step = r_valid && (q_cnt == 2'd0 || (pop && (q_cnt == 2'd1 || n_new != 2'd2)));
  assign in_stall = r_valid && !step;

  assign out_valid = q_cnt != 2'd0;
  assign token_kind = q[0].kind;
  assign token_start = q[0].start;
  assign token_length = q[0].len;
  assign last_of_run = q[0].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
      mode <= scl_pkg::M_IDLE;
      offset <= '0;
      tbegin <= '0;
      tsize <= '0;
      op_kind <= '0;
      kw_buf <= '0;
      kw_ok <= 1'b0;
      q_cnt <= '0;
    end else begin
      if (!in_stall) begin
        r_valid <= in_valid;
        r_char <= character;
        r_end <= end_mark;
      end
      if (step) begin
        mode <= mode_next;
        if (r_end) begin
          offset <= '0;
          tbegin <= '0;
          tsize <= '0;
          op_kind <= '0;
          kw_buf <= '0;
          kw_ok <= 1'b0;
        end else begin
          kw_buf <= kw_buf_next;
          kw_ok <= kw_ok_next;
          op_kind <= op_kind_next;
          offset <= offset + 1'b1;
          if (restart) begin
            tbegin <= offset;
            tsize <= 16'd1;
          end else if (extend && tsize != scl_pkg::LEN_MAX) begin
            tsize <= tsize + 16'd1;
          end
        end
      end
      begin
        logic [1:0] base;
        base = q_cnt - {1'b0, pop};
        if (step && tok_a.valid && base == 2'd0) q[0] <= ra;
        else if (pop) q[0] <= q[1];
        if (step && tok_a.valid && base != 2'd0) q[1] <= ra;
        else if (step && tok_b.valid && base == 2'd0) q[1] <= rb;
        q_cnt <= base + (step ? n_new : 2'd0);
      end
    end
  end

  a_idle: assert property (@(posedge clk) disable iff (rst)
    step && r_end |-> mode_next == scl_pkg::M_IDLE)
    else $error("scan mode not idle after end transaction");
  a_qcap: assert property (@(posedge clk) disable iff (rst) q_cnt != 2'd3)
    else $error("result queue overflow");
  a_tok: assert property (@(posedge clk) disable iff (rst)
    r_valid |-> !(tok_b.valid && !tok_a.valid))
    else $error("second token without first");
  a_end: assert property (@(posedge clk) disable iff (rst)
    step && r_end |=> offset == '0)
    else $error("offset not cleared after end transaction");

endmodule

>>> rtl/core/scl_step.sv
// Combinational next-state and token decode for one source byte.
module scl_step (
  input  scl_pkg::mode_t   mode,
  input  logic [2:0]       kw_count,
  input  logic [39:0]      kw_buf,
  input  logic             kw_ok,
  input  logic [6:0]       op_kind,
  input  logic [7:0]       character,
  input  logic             end_mark,
  output scl_pkg::mode_t   mode_next,
  output logic [39:0]      kw_buf_next,
  output logic             kw_ok_next,
  output logic [6:0]       op_kind_next,
  output logic             extend,
  output logic             restart,
  output scl_pkg::tok_t    tok_a,
  output scl_pkg::tok_t    tok_b
);

  logic          taken;
  logic          do_flush;
  logic [6:0]    flush_kind;
  scl_pkg::tok_t fresh_tok;
  logic [6:0]    ok1;
  logic [6:0]    ok2;

  always_comb begin
    case (mode)
      scl_pkg::M_DEC, scl_pkg::M_ZERO: flush_kind = scl_pkg::K_DEC;
      scl_pkg::M_OCT: flush_kind = scl_pkg::K_OCT;
      scl_pkg::M_HEX: flush_kind = scl_pkg::K_HEX;
      scl_pkg::M_BIN: flush_kind = scl_pkg::K_BIN;
      scl_pkg::M_HEXP, scl_pkg::M_BINP: flush_kind = scl_pkg::K_ERR;
      scl_pkg::M_IDENT: flush_kind = kw_ok ? scl_pkg::kw_kind(kw_buf) : scl_pkg::K_IDENT;
      default: flush_kind = op_kind;
    endcase
  end

  always_comb begin
    ok1 = scl_pkg::one_kind(character);
    ok2 = scl_pkg::dbl_kind(character);
    mode_next = mode;
    kw_buf_next = kw_buf;
    kw_ok_next = kw_ok;
    op_kind_next = op_kind;
    extend = 1'b0;
    restart = 1'b0;
    taken = 1'b0;
    do_flush = 1'b0;
    tok_a = '0;
    tok_b = '0;
    fresh_tok = '0;
    if (end_mark) begin
      if (mode == scl_pkg::M_IDLE) begin
        tok_a = '{valid: 1'b1, kind: scl_pkg::K_END, at_begin: 1'b0,
                  len_sel: scl_pkg::LEN_ZERO};
      end else begin
        tok_a = '{valid: 1'b1, kind: flush_kind, at_begin: 1'b1,
                  len_sel: (mode == scl_pkg::M_OPER) ? scl_pkg::LEN_ONE : scl_pkg::LEN_SIZE};
        tok_b = '{valid: 1'b1, kind: scl_pkg::K_END, at_begin: 1'b0,
                  len_sel: scl_pkg::LEN_ZERO};
      end
      mode_next = scl_pkg::M_IDLE;
    end else begin
      case (mode)
        scl_pkg::M_IDLE: ;
        scl_pkg::M_DEC: begin
          if (scl_pkg::is_dig(character)) taken = 1'b1;
          else do_flush = 1'b1;
        end
        scl_pkg::M_ZERO: begin
          if (scl_pkg::is_oct(character)) begin
            taken = 1'b1;
            mode_next = scl_pkg::M_OCT;
          end else if (character == "8" || character == "9") begin
            tok_a = '{valid: 1'b1, kind: scl_pkg::K_ERR, at_begin: 1'b1,
                      len_sel: scl_pkg::LEN_SIZE};
            mode_next = scl_pkg::M_IDLE;
          end else if (character == "x") begin
            taken = 1'b1;
            mode_next = scl_pkg::M_HEXP;
          end else if (character == "b") begin
            taken = 1'b1;
            mode_next = scl_pkg::M_BINP;
          end else do_flush = 1'b1;
        end
        scl_pkg::M_OCT: begin
          if (scl_pkg::is_oct(character)) taken = 1'b1;
          else do_flush = 1'b1;
        end
        scl_pkg::M_HEXP, scl_pkg::M_HEX: begin
          if (scl_pkg::is_hexc(character)) begin
            taken = 1'b1;
            mode_next = scl_pkg::M_HEX;
          end else do_flush = 1'b1;
        end
        scl_pkg::M_BINP, scl_pkg::M_BIN: begin
          if (character == "0" || character == "1") begin
            taken = 1'b1;
            mode_next = scl_pkg::M_BIN;
          end else do_flush = 1'b1;
        end
        scl_pkg::M_IDENT: begin
          if (character == "_" || scl_pkg::is_alpha(character) ||
              scl_pkg::is_dig(character)) begin
            taken = 1'b1;
            if (kw_ok && kw_count != 3'd5) begin
              case (kw_count)
                3'd1: kw_buf_next[15:8] = character;
                3'd2: kw_buf_next[23:16] = character;
                3'd3: kw_buf_next[31:24] = character;
                3'd4: kw_buf_next[39:32] = character;
                default: kw_buf_next[7:0] = character;
              endcase
            end else kw_ok_next = 1'b0;
          end else do_flush = 1'b1;
        end
        scl_pkg::M_OPER: begin
          if (character == "=" || (character == "+" && op_kind == scl_pkg::K_PLUS) ||
              (character == "-" && op_kind == scl_pkg::K_MINUS) ||
              (character == "&" && op_kind == scl_pkg::K_AMP) ||
              (character == "|" && op_kind == scl_pkg::K_PIPE)) begin
            taken = 1'b1;
            mode_next = scl_pkg::M_IDLE;
            tok_a.valid = 1'b1;
            tok_a.at_begin = 1'b1;
            tok_a.len_sel = scl_pkg::LEN_TWO;
            case (character)
              "=": tok_a.kind = op_kind + 7'd1;
              "+": tok_a.kind = scl_pkg::K_INC;
              "-": tok_a.kind = scl_pkg::K_DECR;
              "&": tok_a.kind = scl_pkg::K_LAND;
              default: tok_a.kind = scl_pkg::K_LOR;
            endcase
          end else do_flush = 1'b1;
        end
        default: mode_next = scl_pkg::M_IDLE;
      endcase
      extend = taken && (mode != scl_pkg::M_OPER);
      if (do_flush) begin
        tok_a = '{valid: 1'b1, kind: flush_kind, at_begin: 1'b1,
                  len_sel: (mode == scl_pkg::M_OPER) ? scl_pkg::LEN_ONE : scl_pkg::LEN_SIZE};
        mode_next = scl_pkg::M_IDLE;
      end
      if (!taken) begin
        fresh_tok.at_begin = 1'b0;
        fresh_tok.len_sel = scl_pkg::LEN_ONE;
        if (character == " " || character == "\t") begin
          mode_next = scl_pkg::M_IDLE;
        end else if (character == "\n") begin
          fresh_tok.valid = 1'b1;
          fresh_tok.kind = scl_pkg::K_NL;
          mode_next = scl_pkg::M_IDLE;
        end else if (character == ";") begin
          fresh_tok.valid = 1'b1;
          fresh_tok.kind = scl_pkg::K_SEMI;
          mode_next = scl_pkg::M_IDLE;
        end else if (scl_pkg::is_dig(character)) begin
          restart = 1'b1;
          mode_next = (character == "0") ? scl_pkg::M_ZERO : scl_pkg::M_DEC;
        end else if (character == "_" || scl_pkg::is_alpha(character)) begin
          restart = 1'b1;
          mode_next = scl_pkg::M_IDENT;
          kw_buf_next = {32'd0, character};
          kw_ok_next = 1'b1;
        end else if (ok1 != 7'd0) begin
          restart = 1'b1;
          fresh_tok.valid = 1'b1;
          fresh_tok.kind = ok1;
          mode_next = scl_pkg::M_IDLE;
        end else if (ok2 != 7'd0) begin
          restart = 1'b1;
          mode_next = scl_pkg::M_OPER;
          op_kind_next = ok2;
        end else begin
          restart = 1'b1;
          fresh_tok.valid = 1'b1;
          fresh_tok.kind = scl_pkg::K_ERR;
          mode_next = scl_pkg::M_IDLE;
        end
        if (tok_a.valid) tok_b = fresh_tok;
        else tok_a = fresh_tok;
      end
    end
  end

endmodule

>>> tb/sv/tb_source_code_lexer.sv
// Self-checking testbench of the source code lexer: directed table, random text, token checks.
module tb_source_code_lexer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int RANDOM_ITEMS = 1550;
  localparam int LONG_RUN     = 80;

  localparam logic [6:0] OP_LPAR = 7'd30, OP_RPAR = 7'd31, OP_LBRK = 7'd32;
  localparam logic [6:0] OP_RBRK = 7'd33, OP_LBRC = 7'd34, OP_RBRC = 7'd35;
  localparam logic [6:0] OP_LT = 7'd36, OP_GT = 7'd38, OP_COLON = 7'd40;
  localparam logic [6:0] OP_QUEST = 7'd41, OP_NOT = 7'd42, OP_STAR = 7'd48;
  localparam logic [6:0] OP_SLASH = 7'd50, OP_PCT = 7'd52, OP_TILDE = 7'd54;
  localparam logic [6:0] OP_CARET = 7'd59, OP_ASSIGN = 7'd61;

  typedef struct packed {
    logic [6:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic        last;
  } token_t;

  typedef struct {
    byte unsigned ch;
    bit           fin;
    bit           typed;
    token_t       tok;
  } row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  character;
  logic        end_mark;
  logic        out_valid;
  logic        out_stall;
  logic [6:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        last_of_run;

  source_code_lexer i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  scl_pkg::mode_t scan_mode;
  logic [15:0] cur_off, tok_beg, tok_size;
  logic [6:0]  op_kind;
  logic [39:0] kw_buf;
  bit          kw_ok;
  token_t      token_q[$];
  token_t      step_q[$];
  int          errors = 0;
  int          n_sent = 0;
  int          cycles = 0;
  int          burst_left = 0;
  bit          no_gaps = 1'b0;

  string kw_names[21] = '{"var", "const", "u8", "u16", "u32", "u64", "u128", "usize",
                          "i8", "i16", "i32", "i64", "i128", "isize", "f32", "f64",
                          "fsize", "size", "char", "str", "bool"};

  function automatic bit digit_ch(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit hex_ch(logic [7:0] c);
    return digit_ch(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic bit word_ch(logic [7:0] c);
    return c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic void put_token(logic [6:0] k, logic [15:0] s, logic [15:0] l);
    token_t t;
    t = '{k, s, l, 1'b0};
    step_q.push_back(t);
  endfunction

  function automatic void grow();
    if (tok_size != scl_pkg::LEN_MAX) tok_size++;
  endfunction

  function automatic logic [6:0] word_kind();
    logic [39:0] v;
    if (!kw_ok) return scl_pkg::K_IDENT;
    for (int i = 0; i < 21; i++) begin
      v = '0;
      for (int j = 0; j < kw_names[i].len(); j++) v |= 40'(kw_names[i][j]) << (8 * j);
      if (v == kw_buf) return scl_pkg::K_KW0 + 7'(i);
    end
    return scl_pkg::K_IDENT;
  endfunction

  function automatic void close_token();
    logic [6:0] k;
    case (scan_mode)
      scl_pkg::M_DEC, scl_pkg::M_ZERO: k = scl_pkg::K_DEC;
      scl_pkg::M_OCT: k = scl_pkg::K_OCT;
      scl_pkg::M_HEX: k = scl_pkg::K_HEX;
      scl_pkg::M_BIN: k = scl_pkg::K_BIN;
      scl_pkg::M_HEXP, scl_pkg::M_BINP: k = scl_pkg::K_ERR;
      scl_pkg::M_IDENT: k = word_kind();
      scl_pkg::M_OPER: k = op_kind;
      default: begin
        scan_mode = scl_pkg::M_IDLE;
        return;
      end
    endcase
    put_token(k, tok_beg, tok_size);
    scan_mode = scl_pkg::M_IDLE;
  endfunction

  function automatic bit extend_token(logic [7:0] c);
    logic [6:0] k;
    case (scan_mode)
      scl_pkg::M_DEC: if (digit_ch(c)) begin
        grow();
        return 1;
      end
      scl_pkg::M_ZERO: begin
        if (c >= "0" && c <= "7") begin
          scan_mode = scl_pkg::M_OCT;
          grow();
          return 1;
        end
        if (c == "8" || c == "9") begin
          put_token(scl_pkg::K_ERR, tok_beg, tok_size);
          scan_mode = scl_pkg::M_IDLE;
          return 0;
        end
        if (c == "x" || c == "b") begin
          scan_mode = (c == "x") ? scl_pkg::M_HEXP : scl_pkg::M_BINP;
          grow();
          return 1;
        end
      end
      scl_pkg::M_OCT: if (c >= "0" && c <= "7") begin
        grow();
        return 1;
      end
      scl_pkg::M_HEXP, scl_pkg::M_HEX: if (hex_ch(c)) begin
        scan_mode = scl_pkg::M_HEX;
        grow();
        return 1;
      end
      scl_pkg::M_BINP, scl_pkg::M_BIN: if (c == "0" || c == "1") begin
        scan_mode = scl_pkg::M_BIN;
        grow();
        return 1;
      end
      scl_pkg::M_IDENT: if (word_ch(c) || digit_ch(c)) begin
        if (kw_ok && tok_size < 5) kw_buf |= 40'(c) << (8 * tok_size);
        else kw_ok = 0;
        grow();
        return 1;
      end
      scl_pkg::M_OPER: begin
        k = '0;
        if (c == "=") k = op_kind + 7'd1;
        else if (c == "+" && op_kind == scl_pkg::K_PLUS) k = scl_pkg::K_INC;
        else if (c == "-" && op_kind == scl_pkg::K_MINUS) k = scl_pkg::K_DECR;
        else if (c == "&" && op_kind == scl_pkg::K_AMP) k = scl_pkg::K_LAND;
        else if (c == "|" && op_kind == scl_pkg::K_PIPE) k = scl_pkg::K_LOR;
        if (k != '0) begin
          put_token(k, tok_beg, 16'd2);
          scan_mode = scl_pkg::M_IDLE;
          return 1;
        end
      end
      default: begin
        scan_mode = scl_pkg::M_IDLE;
        return 0;
      end
    endcase
    close_token();
    return 0;
  endfunction

  function automatic void begin_token(logic [7:0] c);
    logic [6:0] k;
    if (c == " " || c == "\t") return;
    if (c == "\n" || c == ";") begin
      put_token(c == ";" ? scl_pkg::K_SEMI : scl_pkg::K_NL, cur_off, 16'd1);
      return;
    end
    tok_beg = cur_off;
    tok_size = 16'd1;
    if (digit_ch(c)) begin
      scan_mode = (c == "0") ? scl_pkg::M_ZERO : scl_pkg::M_DEC;
      return;
    end
    if (word_ch(c)) begin
      scan_mode = scl_pkg::M_IDENT;
      kw_buf = 40'(c);
      kw_ok = 1;
      return;
    end
    case (c)
      "(": k = OP_LPAR;
      ")": k = OP_RPAR;
      "[": k = OP_LBRK;
      "]": k = OP_RBRK;
      "{": k = OP_LBRC;
      "}": k = OP_RBRC;
      ":": k = OP_COLON;
      "?": k = OP_QUEST;
      "~": k = OP_TILDE;
      default: k = scl_pkg::K_END;
    endcase
    if (k != scl_pkg::K_END) begin
      put_token(k, cur_off, 16'd1);
      return;
    end
    case (c)
      "<": k = OP_LT;
      ">": k = OP_GT;
      "!": k = OP_NOT;
      "+": k = scl_pkg::K_PLUS;
      "-": k = scl_pkg::K_MINUS;
      "*": k = OP_STAR;
      "/": k = OP_SLASH;
      "%": k = OP_PCT;
      "&": k = scl_pkg::K_AMP;
      "|": k = scl_pkg::K_PIPE;
      "^": k = OP_CARET;
      "=": k = OP_ASSIGN;
      default: k = scl_pkg::K_END;
    endcase
    if (k != scl_pkg::K_END) begin
      scan_mode = scl_pkg::M_OPER;
      op_kind = k;
    end else begin
      put_token(scl_pkg::K_ERR, cur_off, 16'd1);
    end
  endfunction

  function automatic void clear_lexer();
    scan_mode = scl_pkg::M_IDLE;
    cur_off = '0;
    tok_beg = '0;
    tok_size = '0;
    op_kind = '0;
    kw_buf = '0;
    kw_ok = 0;
  endfunction

  function automatic void lex_byte(logic [7:0] c, bit fin);
    step_q.delete();
    if (fin) begin
      close_token();
      put_token(scl_pkg::K_END, cur_off, 16'd0);
      clear_lexer();
    end else begin
      if (scan_mode == scl_pkg::M_IDLE || !extend_token(c)) begin_token(c);
      cur_off++;
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
  endfunction

  task automatic send(logic [7:0] c, bit fin, bit typed = 0, token_t tok = '0);
    int gap;
    in_valid <= 1'b1;
    character <= c;
    end_mark <= fin;
    do @(posedge clk); while (in_stall);
    lex_byte(c, fin);
    if (typed) token_q.push_back(tok);
    else foreach (step_q[i]) token_q.push_back(step_q[i]);
    n_sent++;
    if (no_gaps) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120) : $urandom_range(0, 12);
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send(s[i], 0);
  endtask

  function automatic string pick(string set);
    return set.substr($urandom_range(0, set.len() - 1), 0);
  endfunction

  task automatic send_random_token();
    string s;
    int n;
    case ($urandom_range(0, 10))
      0: s = kw_names[$urandom_range(0, 20)];
      1: begin
        s = pick("_abcdefghijklmnopqrstuvwxyzABCXYZ");
        n = $urandom_range(0, 7);
        repeat (n) s = {s, pick("_abcsuiz01234567896ABZ")};
      end
      2: begin
        s = pick("123456789");
        repeat ($urandom_range(0, 5)) s = {s, pick("0123456789")};
      end
      3: begin
        s = "0";
        repeat ($urandom_range(0, 4)) s = {s, pick("0123456789")};
      end
      4: begin
        s = "0x";
        repeat ($urandom_range(0, 4)) s = {s, pick("0123456789abcdefABCDEFg")};
      end
      5: begin
        s = "0b";
        repeat ($urandom_range(0, 5)) s = {s, pick("01012")};
      end
      6: begin
        s = pick("()[]{}<>:?!+-*/%~&|^=");
        if ($urandom_range(0, 1)) s = {s, pick("=+-&|<")};
      end
      7: s = pick(" \t\n;;");
      8: begin
        send(8'($urandom_range(0, 255)), 0);
        return;
      end
      9: if ($urandom_range(0, 5) == 0) begin
        send(8'($urandom_range(0, 255)), 1);
        return;
      end else begin
        s = " ";
      end
      default: s = pick(" \n");
    endcase
    send_text(s);
    if ($urandom_range(0, 2) != 0) send_text(pick("  \t\n;"));
  endtask

  row_t directed[] = '{
    '{";", 0, 1, '{scl_pkg::K_SEMI, 16'd0, 16'd1, 1'b1}},
    '{8'hFF, 0, 1, '{scl_pkg::K_ERR, 16'd1, 16'd1, 1'b1}},
    '{8'h00, 0, 1, '{scl_pkg::K_ERR, 16'd2, 16'd1, 1'b1}},
    '{"\"", 0, 1, '{scl_pkg::K_ERR, 16'd3, 16'd1, 1'b1}},
    '{"0", 0, 0, '0}, '{"x", 0, 0, '0}, '{"g", 0, 0, '0},
    '{"0", 0, 0, '0}, '{"9", 0, 0, '0},
    '{"u", 0, 0, '0}, '{"s", 0, 0, '0}, '{"i", 0, 0, '0}, '{"z", 0, 0, '0},
    '{"e", 0, 0, '0}, '{"\t", 0, 0, '0},
    '{"+", 0, 0, '0}, '{"+", 0, 0, '0}, '{"=", 0, 0, '0}, '{"=", 0, 0, '0},
    '{"&", 0, 0, '0}, '{"&", 0, 0, '0}, '{"\n", 0, 0, '0},
    '{"0", 0, 0, '0}, '{"b", 0, 0, '0}, '{8'h00, 1, 0, '0},
    '{8'h7F, 1, 1, '{scl_pkg::K_END, 16'd0, 16'd0, 1'b1}}
  };

  always @(posedge clk) begin
    token_t e;
    if (!rst && out_valid && !out_stall) begin
      if (token_q.size() == 0) begin
        $display("%0t: unexpected token kind=%0d start=%0d len=%0d last=%0b", $time,
                 token_kind, token_start, token_length, last_of_run);
        errors++;
      end else begin
        e = token_q.pop_front();
        if (token_kind !== e.kind) begin
          $display("%0t: token_kind expected %0d actual %0d", $time, e.kind, token_kind);
          errors++;
        end
        if (token_start !== e.start) begin
          $display("%0t: token_start expected %0d actual %0d", $time, e.start, token_start);
          errors++;
        end
        if (token_length !== e.len) begin
          $display("%0t: token_length expected %0d actual %0d", $time, e.len, token_length);
          errors++;
        end
        if (last_of_run !== e.last) begin
          $display("%0t: last_of_run expected %0b actual %0b", $time, e.last, last_of_run);
          errors++;
        end
      end
    end
  end

  int  hold_left = 0;
  bit  held = 0;
  int  stall_pct = 0;
  always @(posedge clk) begin
    if (cycles % 64 == 0) stall_pct = $urandom_range(0, 4) * 20;
    if (!held && n_sent >= 120) begin
      held = 1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    character <= '0;
    end_mark <= 1'b0;
    out_stall <= 1'b0;
    clear_lexer();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i])
      send(directed[i].ch, directed[i].fin, directed[i].typed, directed[i].tok);
    while (n_sent < RANDOM_ITEMS + directed.size()) send_random_token();
    send(8'h00, 1);
    no_gaps = 1;
    repeat (LONG_RUN) send("a", 0);
    send("1", 0);
    send(8'h00, 1);
    in_valid <= 1'b0;
    while (token_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> source_code_lexer.f
rtl/core/scl_pkg.sv
rtl/core/scl_step.sv
rtl/core/source_code_lexer.sv
tb/sv/tb_source_code_lexer.sv
